// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk_i, rst_n_i, cond, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (cond)) \
		else $error(msg);
// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_i, rst_n_i, cond, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (cond)) \
		else $error(msg);
`endif

// ===== sv/dsa_pkg.sv =====
// Package of shared constants and types for the strategy adaptation block.
package dsa_pkg;
	localparam int NUM_STRATEGIES_DEF = 5;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int POP_MAX_DEF = 256;
	localparam int CNT_W = 9;
	localparam int PROB_W = 17;
	localparam int WLEN_W = 7;
	localparam int U_W = 16;
	localparam int SIDX_W = 3;
	localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
	localparam logic [16:0] EPS_Q16 = 17'd655;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [6:0] WLEN_RESET = 7'd50;
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Request to the divider and its answer.
	typedef struct packed {
		logic        start;
		logic [40:0] num;
		logic [23:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [40:0] quo;
	} div_rsp_t;
endpackage

// ===== sv/dsa_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module dsa_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  dsa_pkg::div_req_t req,
	output dsa_pkg::div_rsp_t rsp
);
	import dsa_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [40:0] quo_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [24:0] trial;

	assign trial = {rem_q, quo_q[40]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd41;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[39:0], 1'b1};
			end else begin
				rem_q <= {rem_q[22:0], quo_q[40]};
				quo_q <= {quo_q[39:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q};
endmodule

// ===== sv/de_strategy_adaptation.sv =====
// Top level: SaDE style strategy probability adaptation with a shared divider.
// Plain outcome: counts update on input transfer, then ST_OUT sets out_valid; one item at a time.
// Draw: up to NUM_STRATEGIES roulette steps through one adder and compare, then ST_OUT.
// End of generation: push, drop the oldest records one a cycle; on a drop, read and add up every
// ring record into the window totals, then up to 2*NUM_STRATEGIES divisions.
// Reset (arst_n low, asynchronous) clears counts, ring pointers; sets window_length 50, probs 1/N.
module de_strategy_adaptation #(
	parameter int NUM_STRATEGIES = dsa_pkg::NUM_STRATEGIES_DEF,
	parameter int WINDOW_MAX = dsa_pkg::WINDOW_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [dsa_pkg::WLEN_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic [dsa_pkg::SIDX_W-1:0] strategy_index,
	input  logic                       improved,
	input  logic                       end_of_generation,
	input  logic [dsa_pkg::U_W-1:0]    uniform_draw,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dsa_pkg::SIDX_W-1:0] chosen_strategy,
	output logic                       probs_updated,
	output logic                       window_full
);
	import dsa_pkg::*;

	localparam int SW = (NUM_STRATEGIES > 1) ? $clog2(NUM_STRATEGIES) : 1;
	localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	// Window totals: up to WINDOW_MAX records of 511 each.
	localparam int TW = 24;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DRAW   = 4'd1;
	localparam logic [3:0] ST_PUSH   = 4'd2;
	localparam logic [3:0] ST_SUMRD  = 4'd3;
	localparam logic [3:0] ST_SUMACC = 4'd4;
	localparam logic [3:0] ST_RATE   = 4'd5;
	localparam logic [3:0] ST_RWAIT  = 4'd6;
	localparam logic [3:0] ST_PROB   = 4'd7;
	localparam logic [3:0] ST_PWAIT  = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;
	localparam logic [3:0] ST_EOG    = 4'd10;

	logic [3:0] state_q;
	logic [WLEN_W-1:0] wlen_q;
	logic [CNT_W-1:0] gen_s_q [NUM_STRATEGIES];
	logic [CNT_W-1:0] gen_f_q [NUM_STRATEGIES];
	logic [PROB_W-1:0] prob_q [NUM_STRATEGIES];
	logic [PROB_W-1:0] rate_q [NUM_STRATEGIES];
	logic [TW-1:0] s_tot_q [NUM_STRATEGIES];
	logic [TW-1:0] f_tot_q [NUM_STRATEGIES];
	logic [RW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] walk_q;
	logic [SW-1:0] j_q;
	logic [U_W-1:0] u_q;
	logic [PROB_W+SW:0] cum_q;
	logic [19:0] rsum_q;
	logic dropped_q;
	logic [SIDX_W-1:0] chosen_q;
	logic upd_q;
	logic full_q;
	logic ovalid_q;

	// Ring memories: one record (all strategies) per row, registered read.
	logic [NUM_STRATEGIES*CNT_W-1:0] s_mem [WINDOW_MAX];
	logic [NUM_STRATEGIES*CNT_W-1:0] f_mem [WINDOW_MAX];
	logic [NUM_STRATEGIES*CNT_W-1:0] s_rd_q, f_rd_q, s_wr, f_wr;
	logic wr_en;
	logic [RW-1:0] wr_addr, rd_addr;

	div_req_t dreq;
	div_rsp_t drsp;

	dsa_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [CW-1:0] len_eff;
	logic any_s;
	logic [PROB_W+SW:0] cum_nx;
	logic [CW:0] slot_sum;

	always_comb begin
		if (wlen_q == '0) len_eff = CW'(1);
		else if (32'(wlen_q) > WINDOW_MAX) len_eff = CW'(WINDOW_MAX);
		else len_eff = CW'(wlen_q);
		any_s = 1'b0;
		for (int j = 0; j < NUM_STRATEGIES; j++) begin
			if (gen_s_q[j] != '0) any_s = 1'b1;
			s_wr[j*CNT_W +: CNT_W] = gen_s_q[j];
			f_wr[j*CNT_W +: CNT_W] = gen_f_q[j];
		end
		cum_nx = cum_q + (PROB_W+SW+1)'(prob_q[j_q]);
		slot_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
		if (slot_sum >= (CW+1)'(WINDOW_MAX)) slot_sum = slot_sum - (CW+1)'(WINDOW_MAX);
		wr_addr = RW'(slot_sum);
		slot_sum = (CW+1)'(head_q) + (CW+1)'(walk_q);
		if (slot_sum >= (CW+1)'(WINDOW_MAX)) slot_sum = slot_sum - (CW+1)'(WINDOW_MAX);
		rd_addr = RW'(slot_sum);
		wr_en = (state_q == ST_PUSH) && any_s;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			s_mem[wr_addr] <= s_wr;
			f_mem[wr_addr] <= f_wr;
		end
		s_rd_q <= s_mem[rd_addr];
		f_rd_q <= f_mem[rd_addr];
	end

	assign cfg_ready = (state_q == ST_IDLE) && !ovalid_q;
	assign in_ready = (state_q == ST_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign chosen_strategy = chosen_q;
	assign probs_updated = upd_q;
	assign window_full = full_q;

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = '0;
		dreq.den = '0;
		if (state_q == ST_RATE) begin
			dreq.start = (s_tot_q[j_q] + f_tot_q[j_q]) != '0;
			dreq.num = {1'b0, s_tot_q[j_q], 16'd0};
			dreq.den = s_tot_q[j_q] + f_tot_q[j_q];
		end else if (state_q == ST_PROB) begin
			dreq.start = 1'b1;
			dreq.num = 41'({rate_q[j_q], 16'd0});
			dreq.den = 24'(rsum_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wlen_q <= WLEN_RESET;
			head_q <= '0;
			count_q <= '0;
			walk_q <= '0;
			j_q <= '0;
			ovalid_q <= 1'b0;
			dropped_q <= 1'b0;
			for (int j = 0; j < NUM_STRATEGIES; j++) begin
				gen_s_q[j] <= '0;
				gen_f_q[j] <= '0;
				prob_q[j] <= PROB_W'(ONE_Q16 / 17'(NUM_STRATEGIES));
			end
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (cfg_valid && cfg_ready) wlen_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					// Take one item; an outcome updates the counts at once.
					if (in_valid && in_ready) begin
						u_q <= uniform_draw;
						cum_q <= '0;
						j_q <= '0;
						chosen_q <= '0;
						upd_q <= 1'b0;
						dropped_q <= 1'b0;
						if (opcode == OP_DRAW) begin
							state_q <= ST_DRAW;
						end else begin
							if (32'(strategy_index) < NUM_STRATEGIES) begin
								if (improved) begin
									if (gen_s_q[SW'(strategy_index)] < COUNT_MAX)
										gen_s_q[SW'(strategy_index)] <= gen_s_q[SW'(strategy_index)] + 1'b1;
								end else begin
									if (gen_f_q[SW'(strategy_index)] < COUNT_MAX)
										gen_f_q[SW'(strategy_index)] <= gen_f_q[SW'(strategy_index)] + 1'b1;
								end
							end
							state_q <= end_of_generation ? ST_PUSH : ST_OUT;
						end
					end
				end
				ST_DRAW: begin
					// Advance the roulette one strategy per cycle.
					cum_q <= cum_nx;
					if ((PROB_W+SW+1)'(u_q) < cum_nx) begin
						chosen_q <= SIDX_W'(j_q);
						state_q <= ST_OUT;
					end else if (32'(j_q) == NUM_STRATEGIES - 1) begin
						chosen_q <= SIDX_W'(NUM_STRATEGIES - 1);
						state_q <= ST_OUT;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_PUSH: begin
					// Push the generation record if it holds a success, making room if the physical ring is full.
					if (any_s) begin
						if (count_q >= CW'(WINDOW_MAX)) begin
							head_q <= (32'(head_q) == WINDOW_MAX - 1) ? '0 : head_q + 1'b1;
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
					for (int j = 0; j < NUM_STRATEGIES; j++) begin
						gen_s_q[j] <= '0;
						gen_f_q[j] <= '0;
					end
					state_q <= ST_EOG;
				end
				ST_EOG: begin
					// Drop the oldest records one a cycle until within the period.
					if (count_q > len_eff) begin
						head_q <= (32'(head_q) == WINDOW_MAX - 1) ? '0 : head_q + 1'b1;
						count_q <= count_q - 1'b1;
						dropped_q <= 1'b1;
					end else if (dropped_q) begin
						walk_q <= '0;
						for (int j = 0; j < NUM_STRATEGIES; j++) begin
							s_tot_q[j] <= '0;
							f_tot_q[j] <= '0;
						end
						state_q <= ST_SUMRD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SUMRD: begin
					state_q <= ST_SUMACC;
				end
				ST_SUMACC: begin
					for (int j = 0; j < NUM_STRATEGIES; j++) begin
						s_tot_q[j] <= s_tot_q[j] + TW'(s_rd_q[j*CNT_W +: CNT_W]);
						f_tot_q[j] <= f_tot_q[j] + TW'(f_rd_q[j*CNT_W +: CNT_W]);
					end
					if (walk_q + 1'b1 >= count_q) begin
						j_q <= '0;
						rsum_q <= '0;
						state_q <= ST_RATE;
					end else begin
						walk_q <= walk_q + 1'b1;
						state_q <= ST_SUMRD;
					end
				end
				ST_RATE: begin
					if ((s_tot_q[j_q] + f_tot_q[j_q]) == '0) begin
						rate_q[j_q] <= EPS_Q16;
						rsum_q <= rsum_q + 20'(EPS_Q16);
						if (32'(j_q) == NUM_STRATEGIES - 1) begin
							j_q <= '0;
							state_q <= ST_PROB;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						state_q <= ST_RWAIT;
					end
				end
				ST_RWAIT: begin
					if (drsp.done) begin
						rate_q[j_q] <= EPS_Q16 + PROB_W'(drsp.quo);
						rsum_q <= rsum_q + 20'(EPS_Q16) + 20'(drsp.quo);
						if (32'(j_q) == NUM_STRATEGIES - 1) begin
							j_q <= '0;
							state_q <= ST_PROB;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= ST_RATE;
						end
					end
				end
				ST_PROB: begin
					state_q <= ST_PWAIT;
				end
				ST_PWAIT: begin
					if (drsp.done) begin
						prob_q[j_q] <= PROB_W'(drsp.quo);
						if (32'(j_q) == NUM_STRATEGIES - 1) begin
							upd_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= ST_PROB;
						end
					end
				end
				ST_OUT: begin
					// Hold the result in the output register until the transfer.
					full_q <= count_q >= len_eff;
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/dsa_checker.sv =====
// Port-level checker for the strategy adaptation block, with its bind.
`include "assert_macros.svh"
module dsa_checker #(
	parameter int NUM_STRATEGIES = dsa_pkg::NUM_STRATEGIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] chosen_strategy,
	input logic       probs_updated
);
	`ASSERT_IMPL(a_out_hold, clk, arst_n, !($past(out_valid) && !$past(out_ready)) || (out_valid && $stable(chosen_strategy)), "result changed while stalled")
	`ASSERT_ALWAYS(a_no_take_busy, clk, arst_n, !(out_valid && in_ready), "input taken while result pending")
	`ASSERT_ALWAYS(a_range, clk, arst_n, !out_valid || 32'(chosen_strategy) < NUM_STRATEGIES, "strategy out of range")
	`ASSERT_ALWAYS(a_draw_noupd, clk, arst_n, !out_valid || !probs_updated || chosen_strategy == 3'd0, "update flagged on draw")
endmodule

bind de_strategy_adaptation dsa_checker #(.NUM_STRATEGIES(NUM_STRATEGIES)) u_dsa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.chosen_strategy(chosen_strategy), .probs_updated(probs_updated)
);
